FILE: rtl/rlec_pkg.sv
// Package for the escaped-count run-length encoder.
// Word types, function and status codes, slot constants. No dependencies.
`timescale 1ns / 1ps

package rlec_pkg;

	// function codes
	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	// status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ZERO     = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	// slot width codes
	localparam logic [1:0] SLOT_W1 = 2'd0;
	localparam logic [1:0] SLOT_W2 = 2'd1;

	// config register indexes
	localparam logic CFG_MIN_SLOT_WIDTH = 1'b0;
	localparam logic CFG_START_LEVEL    = 1'b1;

	// escape values and length limit
	localparam logic [7:0]  ESC8      = 8'hff;
	localparam logic [15:0] ESC16     = 16'hffff;
	localparam logic [32:0] LEN_LIMIT = 33'h0_ffff_ffff;

	localparam int MAX_BYTES = 7;

	typedef struct packed {
		logic        func;
		logic        level;
		logic [31:0] sample_count;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic [1:0] status;
	} out_word_t;

	// one item's worth of output bytes, byte 0 goes out first
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                n;
		logic [1:0]                status;
	} rec_t;

endpackage

FILE: rtl/rlec_encode.sv
// Run state, config registers and per-item record formation.
// Depends on rlec_pkg.
`timescale 1ns / 1ps

module rlec_encode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  rlec_pkg::in_word_t in_word,
	input  logic             cfg_fire,
	input  logic             cfg_index,
	input  logic [1:0]       cfg_data,
	output logic             rec_push,
	output rlec_pkg::rec_t   rec
);
	import rlec_pkg::*;

	logic [1:0]  min_slot_width_q;
	logic        start_level_q;
	logic        run_level_q;
	logic [31:0] run_length_q;

	logic [32:0] sum;
	logic        ovf;
	logic        push_c;
	logic        level_d;
	logic [31:0] length_d;
	rec_t        emit_rec;
	rec_t        rec_c;

	// encode current run into escaped little-endian slots
	function automatic rec_t emit(input logic [31:0] len, input logic [1:0] w);
		rec_t r;
		r.bytes  = '0;
		r.status = STATUS_OK;
		if (w == SLOT_W1 && len < 32'(ESC8)) begin
			r.bytes[0] = len[7:0];
			r.n        = 3'd1;
		end else if (w == SLOT_W1 && len < 32'(ESC16)) begin
			r.bytes[0] = ESC8;
			r.bytes[1] = len[7:0];
			r.bytes[2] = len[15:8];
			r.n        = 3'd3;
		end else if (w == SLOT_W1) begin
			r.bytes[0] = ESC8;
			r.bytes[1] = ESC16[7:0];
			r.bytes[2] = ESC16[15:8];
			r.bytes[3] = len[7:0];
			r.bytes[4] = len[15:8];
			r.bytes[5] = len[23:16];
			r.bytes[6] = len[31:24];
			r.n        = 3'd7;
		end else if (w == SLOT_W2 && len < 32'(ESC16)) begin
			r.bytes[0] = len[7:0];
			r.bytes[1] = len[15:8];
			r.n        = 3'd2;
		end else if (w == SLOT_W2) begin
			r.bytes[0] = ESC16[7:0];
			r.bytes[1] = ESC16[15:8];
			r.bytes[2] = len[7:0];
			r.bytes[3] = len[15:8];
			r.bytes[4] = len[23:16];
			r.bytes[5] = len[31:24];
			r.n        = 3'd6;
		end else begin
			r.bytes[0] = len[7:0];
			r.bytes[1] = len[15:8];
			r.bytes[2] = len[23:16];
			r.bytes[3] = len[31:24];
			r.n        = 3'd4;
		end
		return r;
	endfunction

	assign sum      = {1'b0, run_length_q} + {1'b0, in_word.sample_count};
	assign ovf      = sum >= LEN_LIMIT;
	assign emit_rec = emit(run_length_q, min_slot_width_q);

	always_comb begin
		push_c   = 1'b0;
		level_d  = run_level_q;
		length_d = run_length_q;
		rec_c    = emit_rec;
		if (in_word.func == FUNC_FLUSH) begin
			push_c   = 1'b1;
			level_d  = start_level_q;
			length_d = '0;
		end else if (in_word.sample_count == '0) begin
			push_c          = 1'b1;
			rec_c.bytes     = '0;
			rec_c.n         = 3'd1;
			rec_c.status    = STATUS_ZERO;
		end else if (in_word.level == run_level_q) begin
			if (ovf) begin
				push_c       = 1'b1;
				rec_c.bytes  = '0;
				rec_c.n      = 3'd1;
				rec_c.status = STATUS_OVERFLOW;
			end else begin
				length_d = sum[31:0];
			end
		end else begin
			push_c   = 1'b1;
			level_d  = in_word.level;
			length_d = in_word.sample_count;
		end
	end

	assign rec_push = in_fire && push_c;
	assign rec      = rec_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_slot_width_q <= '0;
			start_level_q    <= 1'b0;
			run_level_q      <= 1'b0;
			run_length_q     <= '0;
		end else if (cfg_fire) begin
			if (cfg_index == CFG_MIN_SLOT_WIDTH) begin
				min_slot_width_q <= cfg_data;
			end else begin
				start_level_q <= cfg_data[0];
				if (run_length_q == '0) begin
					run_level_q <= cfg_data[0];
				end
			end
		end else if (in_fire) begin
			run_level_q  <= level_d;
			run_length_q <= length_d;
		end
	end

endmodule

FILE: rtl/rlec_fifo.sv
// Two-entry record queue between the encoder and the byte serializer.
// Depends on rlec_pkg.
`timescale 1ns / 1ps

module rlec_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rlec_pkg::rec_t push_rec,
	input  logic           pop,
	output logic           full,
	output logic           nonempty,
	output rlec_pkg::rec_t head
);
	import rlec_pkg::*;

	rec_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = count_q == 2'd2;
	assign nonempty = count_q != 2'd0;
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/rlec_serial.sv
// Byte serializer: holds one record and hands out its bytes one word a cycle while out_ready is high.
// Depends on rlec_pkg.
`timescale 1ns / 1ps

module rlec_serial (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_avail,
	input  rlec_pkg::rec_t      rec,
	output logic                rec_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output rlec_pkg::out_word_t out_word
);
	import rlec_pkg::*;

	rec_t       cur_q;
	logic [2:0] idx_q;
	logic       busy_q;
	logic       is_last;
	logic       done;

	assign is_last = idx_q == cur_q.n - 3'd1;
	assign done    = busy_q && out_ready && is_last;
	assign rec_pop = (!busy_q || done) && rec_avail;

	assign out_valid         = busy_q;
	assign out_word.out_byte = cur_q.bytes[idx_q];
	assign out_word.last     = is_last;
	assign out_word.status   = cur_q.status;

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			cur_q <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (rec_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && out_ready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

endmodule

FILE: rtl/run_length_encoder_escaped_counts_top.sv
// Escaped-count run-length encoder, top level.
// From an item's acceptance to its first byte word at an idle output, its record is
// written into the queue at acceptance and then loaded into the serializer.
// Throughput: one item per cycle while the record queue has room; output runs at one
// byte per cycle while out_ready is high, so an item's 1 to 7 bytes set the sustained rate.
// Reset (arst_n, async low): run empty, level 0, slot width code 0, queue empty.
// Depends on rlec_pkg, rlec_encode, rlec_fifo, rlec_serial.
`timescale 1ns / 1ps

module run_length_encoder_escaped_counts_top (
	input  logic                clk,
	input  logic                arst_n,
	// input items
	input  logic                in_valid,
	output logic                in_ready,
	input  rlec_pkg::in_word_t  in_data,
	// encoded bytes
	output logic                out_valid,
	input  logic                out_ready,
	output rlec_pkg::out_word_t out_data,
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [1:0]          cfg_data
);
	import rlec_pkg::*;

	logic in_fire;
	logic cfg_fire;
	logic rec_push;
	rec_t rec;
	logic fifo_full;
	logic fifo_nonempty;
	rec_t fifo_head;
	logic rec_pop;

	// items are taken whenever the queue can absorb a record; extensions
	// push no record but also wait for room
	assign in_ready  = !fifo_full;
	assign in_fire   = in_valid && in_ready;
	// config is only to be written while idle, a rule on the user that this block leaves unchecked; always take it
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid;

	// run state update and record build, single pass per word
	rlec_encode u_encode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_word  (in_data),
		.cfg_fire (cfg_fire),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rec_push (rec_push),
		.rec      (rec)
	);

	// decouples input side from a stalled output
	rlec_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (rec_push),
		.push_rec(rec),
		.pop     (rec_pop),
		.full    (fifo_full),
		.nonempty(fifo_nonempty),
		.head    (fifo_head)
	);

	// one byte word per cycle from the held record while out_ready is high
	rlec_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_avail(fifo_nonempty),
		.rec      (fifo_head),
		.rec_pop  (rec_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_data)
	);

	// error words are always single and final
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STATUS_OK |-> out_data.last)
		else $error("error word without last");

	// a flush always yields a record
	a_flush_push: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.func == FUNC_FLUSH |-> rec_push)
		else $error("flush produced no record");

	// records carry 1..7 bytes, errors exactly one
	a_rec_len: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |-> rec.n != 3'd0 && (rec.status == STATUS_OK || rec.n == 3'd1))
		else $error("bad record length");

endmodule
